// ===== hw/rtl/tsrq_pkg.sv =====
// shared types and constants of the track-sorted request queue
package tsrq_pkg;

	localparam int TRK_W = 12;
	localparam int TAG_W = 8;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_POP    = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_POP_EMPTY = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef struct packed {
		op_t              opcode;
		logic [TRK_W-1:0] req_track;
		logic [TAG_W-1:0] req_tag;
	} req_t;

	typedef struct packed {
		logic             out_valid;
		logic [TAG_W-1:0] out_tag;
		logic [TRK_W-1:0] out_track;
		logic             is_empty;
		status_t          status;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_POP_WAIT,
		S_INS_RD,
		S_INS_CMP,
		S_FINISH
	} state_t;

endpackage

// ===== hw/rtl/tsrq_ram.sv =====
// entry storage: one write port, one read port with registered read data
module tsrq_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int W     = 20
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/track_sorted_request_queue.sv =====
// top level of the track-sorted request queue: sequencer, address unit and result register
// Holds up to DEPTH requests in ascending track order, equal tracks in arrival
// order, in a circular buffer whose head moves on every pop from a non-empty
// queue. An insert walks the buffer from the tail with the single read port and
// the shared address adder, passing through S_INS_RD and S_INS_CMP for every
// stored entry with a higher track. A pop on an empty queue or an insert into a
// full one goes from decode straight to the result. The next transfer is taken
// in S_IDLE, which follows the loading of the result. Each transfer gives exactly
// one result; a new request is taken while the last result still waits in the
// output register. No clearing pass after reset.
module track_sorted_request_queue #(
	parameter int DEPTH      = 16,
	parameter int TRACK_BITS = 12
) (
	input  logic           clk,
	input  logic           arst_n,
	input  tsrq_pkg::req_t req,
	input  logic           req_valid,
	output logic           req_stall,
	output tsrq_pkg::rsp_t rsp,
	output logic           rsp_valid,
	input  logic           rsp_stall
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = AW + 1;
	localparam int EW = TRACK_BITS + tsrq_pkg::TAG_W;

	tsrq_pkg::state_t state_q, state_d;

	tsrq_pkg::req_t req_q;
	logic [AW-1:0]  head_q;
	logic [CW-1:0]  count_q;
	logic [CW-1:0]  idx_q;

	logic                      res_valid_q;
	logic [tsrq_pkg::TAG_W-1:0] res_tag_q;
	logic [TRACK_BITS-1:0]     res_track_q;
	tsrq_pkg::status_t         res_status_q;

	tsrq_pkg::rsp_t rsp_q;
	logic           rsp_valid_q;

	logic [CW-1:0]         lidx;
	logic [SW-1:0]         sum;
	logic [AW-1:0]         phys;
	logic                  ram_we;
	logic [EW-1:0]         ram_wdata;
	logic [EW-1:0]         ram_rdata;
	logic [TRACK_BITS-1:0] new_track;
	logic [TRACK_BITS-1:0] rd_track;
	logic                  shift_up;
	logic                  out_free;

	assign new_track = TRACK_BITS'(req_q.req_track);
	assign rd_track  = ram_rdata[EW-1 -: TRACK_BITS];
	assign shift_up  = rd_track > new_track;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	// shared address unit: logical position to buffer slot
	always_comb begin
		lidx = idx_q;
		if (state_q == tsrq_pkg::S_DECODE) begin
			lidx = '0;
		end else if (state_q == tsrq_pkg::S_INS_RD && idx_q != '0) begin
			lidx = idx_q - CW'(1);
		end
		sum = SW'(head_q) + SW'(lidx);
		if (sum >= SW'(DEPTH)) begin
			phys = AW'(sum - SW'(DEPTH));
		end else begin
			phys = AW'(sum);
		end
	end

	tsrq_ram #(
		.DEPTH(DEPTH),
		.AW   (AW),
		.W    (EW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(phys),
		.wdata(ram_wdata),
		.raddr(phys),
		.rdata(ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tsrq_pkg::S_IDLE: begin
				if (req_valid) begin
					state_d = tsrq_pkg::S_DECODE;
				end
			end
			tsrq_pkg::S_DECODE: begin
				if (req_q.opcode == tsrq_pkg::OP_POP) begin
					state_d = (count_q == '0) ? tsrq_pkg::S_FINISH : tsrq_pkg::S_POP_WAIT;
				end else begin
					state_d = (count_q == CW'(DEPTH)) ? tsrq_pkg::S_FINISH : tsrq_pkg::S_INS_RD;
				end
			end
			tsrq_pkg::S_POP_WAIT: state_d = tsrq_pkg::S_FINISH;
			tsrq_pkg::S_INS_RD: begin
				state_d = (idx_q == '0) ? tsrq_pkg::S_FINISH : tsrq_pkg::S_INS_CMP;
			end
			tsrq_pkg::S_INS_CMP: begin
				state_d = shift_up ? tsrq_pkg::S_INS_RD : tsrq_pkg::S_FINISH;
			end
			tsrq_pkg::S_FINISH: begin
				if (out_free) begin
					state_d = tsrq_pkg::S_IDLE;
				end
			end
			default: state_d = tsrq_pkg::S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		req_stall = 1'b1;
		ram_we    = 1'b0;
		ram_wdata = {new_track, req_q.req_tag};
		case (state_q)
			tsrq_pkg::S_IDLE: req_stall = 1'b0;
			tsrq_pkg::S_INS_RD: begin
				ram_we = (idx_q == '0);
			end
			tsrq_pkg::S_INS_CMP: begin
				ram_we = 1'b1;
				if (shift_up) begin
					ram_wdata = ram_rdata;
				end
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tsrq_pkg::S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				tsrq_pkg::S_POP_WAIT: begin
					head_q  <= (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
					count_q <= count_q - CW'(1);
				end
				tsrq_pkg::S_INS_RD: begin
					if (idx_q == '0) begin
						count_q <= count_q + CW'(1);
					end
				end
				tsrq_pkg::S_INS_CMP: begin
					if (!shift_up) begin
						count_q <= count_q + CW'(1);
					end
				end
				default: begin
					count_q <= count_q;
				end
			endcase
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (state_q == tsrq_pkg::S_FINISH && out_free) begin
				rsp_valid_q <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			tsrq_pkg::S_IDLE: begin
				if (req_valid) begin
					req_q <= req;
				end
			end
			tsrq_pkg::S_DECODE: begin
				idx_q        <= count_q;
				res_valid_q  <= 1'b0;
				res_tag_q    <= '0;
				res_track_q  <= '0;
				res_status_q <= tsrq_pkg::ST_OK;
				if (req_q.opcode == tsrq_pkg::OP_POP) begin
					if (count_q == '0) begin
						res_status_q <= tsrq_pkg::ST_POP_EMPTY;
					end
				end else if (count_q == CW'(DEPTH)) begin
					res_status_q <= tsrq_pkg::ST_FULL;
				end
			end
			tsrq_pkg::S_POP_WAIT: begin
				res_valid_q <= 1'b1;
				res_tag_q   <= ram_rdata[tsrq_pkg::TAG_W-1:0];
				res_track_q <= rd_track;
			end
			tsrq_pkg::S_INS_CMP: begin
				// entry moved up one slot, continue toward the head
				if (shift_up) begin
					idx_q <= idx_q - CW'(1);
				end
			end
			tsrq_pkg::S_FINISH: begin
				if (out_free) begin
					rsp_q.out_valid <= res_valid_q;
					rsp_q.out_tag   <= res_tag_q;
					rsp_q.out_track <= tsrq_pkg::TRK_W'(res_track_q);
					rsp_q.is_empty  <= (count_q == '0);
					rsp_q.status    <= res_status_q;
				end
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule
